>>> rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the item types of both channels, the register map and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // APB address width: five 64-bit registers at 8-byte spacing
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // register indexes (paddr[5:3])
  typedef enum logic [2:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_REPLACE_ALL        = 3'd4
  } reg_index_t;

  // replacement text holds at most eight bytes
  localparam logic [3:0] MAX_REPLACEMENT = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
    logic        replace_all;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take the input item into the buffer
    logic emit_buf;  // send the byte at the scan pointer, advance it
    logic emit_rep;  // send the next replacement byte
    logic set_done;  // close a full match
    logic finish;    // close the item, mark its last result, keep held bytes
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lt_plain;  // bytes remain that go out unchanged
    logic lt_n;      // bytes remain to scan
    logic match;     // remaining bytes are a pattern prefix
    logic full;      // ... and cover the whole pattern
    logic rep_left;  // replacement bytes remain
    logic fin;       // item carries the end mark
    logic out_free;  // output register can take a result
  } status_t;

endpackage

>>> rtl/core/sfr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_regs: configuration registers
// APB write and read access to the pattern, replacement and mode registers.
// ----------------------------------------------------------------------------
module sfr_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic [sfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sfr_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[5:3];

  // write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes      <= '0;
      cfg.pattern_length     <= '0;
      cfg.replacement_bytes  <= '0;
      cfg.replacement_length <= '0;
      cfg.replace_all        <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        sfr_pkg::REG_PATTERN_BYTES:      cfg.pattern_bytes      <= pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:     cfg.pattern_length     <= pwdata[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= pwdata;
        sfr_pkg::REG_REPLACEMENT_LENGTH: cfg.replacement_length <= pwdata[3:0];
        sfr_pkg::REG_REPLACE_ALL:        cfg.replace_all        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      sfr_pkg::REG_PATTERN_BYTES:      prdata = cfg.pattern_bytes;
      sfr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, cfg.pattern_length};
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = cfg.replacement_bytes;
      sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg.replacement_length};
      sfr_pkg::REG_REPLACE_ALL:        prdata = {63'd0, cfg.replace_all};
      default:                         prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/sfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ctrl: item sequencer
// Steps one item through unchanged release, prefix scan, replacement and
// end-of-text flush, issuing at most one datapath command per cycle; an output stall holds it in place.
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  sfr_pkg::status_t  stat,
  output sfr_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PLAIN = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_REPL  = 6'b001000,
    ST_TAIL  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  assign src_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (src_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PLAIN;
        end
      end
      ST_PLAIN: begin
        if (stat.lt_plain) begin
          cmd.emit_buf = stat.out_free;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (!stat.lt_n) begin
          state_next = ST_TAIL;
        end else if (stat.match) begin
          state_next = stat.full ? ST_REPL : ST_TAIL;
        end else begin
          cmd.emit_buf = stat.out_free;
        end
      end
      ST_REPL: begin
        if (stat.rep_left) begin
          cmd.emit_rep = stat.out_free;
        end else begin
          cmd.set_done = 1'b1;
          state_next   = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // flush held bytes at end of text, then close the item
        if (stat.fin && stat.lt_n) begin
          cmd.emit_buf = stat.out_free;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  // commands other than load only issue while an item is in work
  a_no_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(cmd.emit_buf || cmd.emit_rep || cmd.finish || cmd.set_done))
    else $error("datapath command issued while idle");
  // an accepted item always leaves idle
  a_load_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_PLAIN))
    else $error("load did not start the item");
  // replacement closes into the tail step
  a_done_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.set_done |=> (state == ST_TAIL))
    else $error("match close went astray");
`endif

endmodule

>>> rtl/core/sfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_dp: find-and-replace datapath
// Byte buffer with scan pointer, prefix compare, replacement counter, a
// one-deep pending result and the output register.
// ----------------------------------------------------------------------------
module sfr_dp #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::cfg_t        cfg,
  input  sfr_pkg::in_item_t    src_data,
  input  sfr_pkg::cmd_t        cmd,
  output sfr_pkg::status_t     stat,
  output logic                 res_valid,
  input  logic                 res_stall,
  output sfr_pkg::out_item_t   res_data
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // buffer: held bytes followed by the new byte
  logic [7:0]    buf_mem [MAX_PATTERN];
  logic [CW-1:0] held_count;
  logic [CW-1:0] n;
  logic [CW-1:0] start;
  logic [CW-1:0] plain;
  logic [3:0]    rep_idx;
  logic          fin;
  logic          first_done;

  // one result waits until the next shows whether it was the last
  logic          pend_valid;
  logic [7:0]    pend_byte;

  logic [3:0]    plen;
  logic [3:0]    rlen;
  logic          pass;
  logic [CW-1:0] m;
  logic          match;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_byte;

  assign plen = (cfg.pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                       : cfg.pattern_length;
  assign rlen = (cfg.replacement_length > sfr_pkg::MAX_REPLACEMENT)
                ? sfr_pkg::MAX_REPLACEMENT : cfg.replacement_length;
  assign pass = (plen == 4'd0) || (!cfg.replace_all && first_done);
  assign m    = n - start;

  // compare remaining bytes against the pattern prefix
  always_comb begin
    logic [IW-1:0] ix;
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ix = IW'(start + CW'(i));
      if ((CW'(i) < m) && (buf_mem[ix] != cfg.pattern_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign out_free       = !res_valid || !res_stall;
  assign stat.lt_plain  = start < plain;
  assign stat.lt_n      = start < n;
  assign stat.match     = match;
  assign stat.full      = 4'(m) >= plen;
  assign stat.rep_left  = rep_idx < rlen;
  assign stat.fin       = fin;
  assign stat.out_free  = out_free;

  assign emit      = cmd.emit_buf || cmd.emit_rep;
  assign emit_byte = cmd.emit_rep ? cfg.replacement_bytes[8*rep_idx[2:0] +: 8]
                                  : buf_mem[start[IW-1:0]];

  // buffer load and held-byte shift
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_mem[held_count[IW-1:0]] <= src_data.data_byte;
    end else if (cmd.finish) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if ((start + CW'(i)) < n) begin
          buf_mem[i] <= buf_mem[IW'(start + CW'(i))];
        end
      end
    end
  end

  // scan pointer and per-item counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= held_count + CW'(1);
      start   <= '0;
      rep_idx <= '0;
      fin     <= src_data.final_byte;
      priority if (pass) begin
        plain <= held_count + CW'(1);
      end else if (4'(held_count) >= plen) begin
        plain <= held_count;
      end else begin
        plain <= '0;
      end
    end else begin
      if (cmd.emit_buf) begin
        start <= start + CW'(1);
      end
      if (cmd.emit_rep) begin
        rep_idx <= rep_idx + 4'd1;
      end
      if (cmd.set_done) begin
        start <= n;
      end
    end
  end

  // held count and replace-first flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      first_done <= 1'b0;
    end else begin
      if (cmd.set_done) begin
        first_done <= 1'b1;
      end
      if (cmd.finish) begin
        held_count <= fin ? '0 : m;
        if (fin) begin
          first_done <= 1'b0;
        end
      end
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
        pend_byte  <= emit_byte;
        if (pend_valid) begin
          res_valid             <= 1'b1;
          res_data.out_byte     <= pend_byte;
          res_data.byte_present <= 1'b1;
          res_data.run_last     <= 1'b0;
          res_data.text_end     <= 1'b0;
        end
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (pend_valid || fin) begin
          res_valid             <= 1'b1;
          res_data.out_byte     <= pend_valid ? pend_byte : 8'd0;
          res_data.byte_present <= pend_valid;
          res_data.run_last     <= 1'b1;
          res_data.text_end     <= fin;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (emit || cmd.finish) |-> out_free)
    else $error("result register overwritten");
  // closing an item empties the pending stage
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !pend_valid)
    else $error("pending result left after item end");
  // held bytes always fit below the pattern limit
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(MAX_PATTERN - 1))
    else $error("held count out of range");
`endif

endmodule

>>> rtl/core/stream_find_and_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming substring find and replace
// Rewrites a byte stream, putting the configured replacement in place of
// each leftmost non-overlapping match, or the first in replace-first mode.
// ----------------------------------------------------------------------------
// One item is worked at a time; the input stalls from the load until the
// item closes. Each item is loaded, passes the release, scan and tail steps
// and is closed; a full match adds a replacement step that closes it.
// The sequencer walks the byte buffer one position per cycle while the
// output is free, so an item's work grows with the number of bytes that
// leave the block for it. A result waits in a one-deep pending stage until
// it is known whether it is the last one of its item; output stall holds
// the sequencer in place and lengthens the item.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_stall,
  input  sfr_pkg::in_item_t          src_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output sfr_pkg::out_item_t         res_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic [sfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sfr_pkg::cfg_t    cfg;
  sfr_pkg::cmd_t    cmd;
  sfr_pkg::status_t stat;

  sfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfr_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_data  (src_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stream find-and-replace block
// Drives byte texts through the item channel under random gaps and stalls,
// reprograms the pattern, replacement and mode over the APB port between
// phases, and checks every result item against a predictor of the rewrite.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  sfr_pkg::in_item_t src_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  sfr_pkg::out_item_t res_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sfr_pkg::ADDR_W-1:0] paddr = '0;
  logic [sfr_pkg::DATA_W-1:0] pwdata = '0;
  logic [sfr_pkg::DATA_W-1:0] prdata;
  logic pready;

  stream_find_and_replace DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // predictor copy of registers and text state
  logic [63:0] pat_word = '0;
  logic [3:0]  pat_len = '0;
  logic [63:0] rep_word = '0;
  logic [3:0]  rep_len = '0;
  logic        all_mode = 1'b1;
  logic [7:0]  hold_buf [0:7];
  int          hold_cnt = 0;
  bit          replaced = 1'b0;

  sfr_pkg::out_item_t fresh_q[$];
  sfr_pkg::out_item_t rewrite_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;

  function automatic void put_byte(logic [7:0] b, bit present);
    sfr_pkg::out_item_t r;
    r = '0;
    r.out_byte = b;
    r.byte_present = present;
    fresh_q.push_back(r);
  endfunction

  // work out the result items of one input item
  function automatic void predict_rewrite(logic [7:0] b, bit fin);
    int plen;
    int rlen;
    bit pass;
    logic [7:0] scan [0:7];
    int n;
    int start;
    int m;
    bit hit;
    fresh_q.delete();
    plen = (pat_len > 8) ? 8 : pat_len;
    rlen = (rep_len > 8) ? 8 : rep_len;
    pass = (plen == 0) || (!all_mode && replaced);
    // release held bytes unchanged
    if (pass || hold_cnt >= plen) begin
      for (int i = 0; i < hold_cnt; i++) put_byte(hold_buf[i], 1'b1);
      hold_cnt = 0;
    end
    if (pass) begin
      put_byte(b, 1'b1);
    end else begin
      n = 0;
      start = 0;
      for (int i = 0; i < hold_cnt && i < 7; i++) begin
        scan[n] = hold_buf[i];
        n++;
      end
      scan[n] = b;
      n++;
      // drop the oldest byte until the rest is a pattern prefix
      while (start < n) begin
        m = n - start;
        hit = 1'b1;
        for (int i = 0; i < m; i++)
          if (scan[start+i] != pat_word[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          if (m >= plen) begin
            for (int i = 0; i < rlen; i++) put_byte(rep_word[8*i +: 8], 1'b1);
            replaced = 1'b1;
            start = n;
          end
          break;
        end
        put_byte(scan[start], 1'b1);
        start++;
      end
      hold_cnt = n - start;
      for (int i = 0; i < hold_cnt; i++) hold_buf[i] = scan[start+i];
    end
    // flush at end of text
    if (fin) begin
      for (int i = 0; i < hold_cnt; i++) put_byte(hold_buf[i], 1'b1);
      hold_cnt = 0;
      replaced = 1'b0;
      if (fresh_q.size() == 0) put_byte(8'h00, 1'b0);
    end
    if (fresh_q.size() > 0) begin
      fresh_q[fresh_q.size()-1].run_last = 1'b1;
      fresh_q[fresh_q.size()-1].text_end = fin;
    end
  endfunction

  // send one item, optionally overriding the predicted results
  task automatic send_item(logic [7:0] b, bit fin, bit has_exp,
                           sfr_pkg::out_item_t exp_r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= '{data_byte: b, final_byte: fin};
    do @(posedge clk); while (src_stall);
    predict_rewrite(b, fin);
    if (has_exp) rewrite_q.push_back(exp_r);
    else foreach (fresh_q[i]) rewrite_q.push_back(fresh_q[i]);
    items_sent++;
  endtask

  // hold off until the block has drained and settled
  task automatic drain();
    if (src_valid) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    while (rewrite_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sfr_pkg::reg_index_t idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES:      pat_word = v;
      sfr_pkg::REG_PATTERN_LENGTH:     pat_len = v[3:0];
      sfr_pkg::REG_REPLACEMENT_BYTES:  rep_word = v;
      sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = v[3:0];
      default:                         all_mode = v[0];
    endcase
    cfg_writes++;
  endtask

  // directed table
  typedef struct {
    bit                  is_cfg;
    sfr_pkg::reg_index_t idx;
    logic [63:0]         val;
    logic [7:0]          b;
    bit                  fin;
    bit                  has_exp;
    sfr_pkg::out_item_t  exp_r;
  } row_t;

  row_t plan[$];

  function automatic void add_cfg(sfr_pkg::reg_index_t idx, logic [63:0] v);
    row_t r;
    r = '{idx: sfr_pkg::REG_PATTERN_BYTES, default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    plan.push_back(r);
  endfunction

  function automatic void add_item(logic [7:0] b, bit fin, bit has_exp = 0,
                                   sfr_pkg::out_item_t exp_r = '0);
    row_t r;
    r = '{idx: sfr_pkg::REG_PATTERN_BYTES, default: '0};
    r.b = b;
    r.fin = fin;
    r.has_exp = has_exp;
    r.exp_r = exp_r;
    plan.push_back(r);
  endfunction

  // result side: random stall, then compare with the oldest expectation
  initial begin : result_check
    int n;
    sfr_pkg::out_item_t want;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
      results_seen++;
      if (rewrite_q.size() == 0) begin
        $error("unexpected result item %p", res_data);
        errors++;
      end else begin
        want = rewrite_q.pop_front();
        if (res_data.out_byte !== want.out_byte) begin
          $error("out_byte expected %h actual %h", want.out_byte, res_data.out_byte);
          errors++;
        end
        if (res_data.byte_present !== want.byte_present) begin
          $error("byte_present expected %b actual %b", want.byte_present,
                 res_data.byte_present);
          errors++;
        end
        if (res_data.run_last !== want.run_last) begin
          $error("run_last expected %b actual %b", want.run_last, res_data.run_last);
          errors++;
        end
        if (res_data.text_end !== want.text_end) begin
          $error("text_end expected %b actual %b", want.text_end, res_data.text_end);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((src_valid && !src_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [7:0] text_byte(int plen);
    if (plen == 0 || $urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return pat_word[8*$urandom_range(0, plen-1) +: 8];
  endfunction

  initial begin : stimulus
    int plen;
    int left;
    int chunk;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through after reset
    add_item(8'h00, 0, 1, '{8'h00, 1'b1, 1'b1, 1'b0});
    add_item(8'hFF, 0, 1, '{8'hFF, 1'b1, 1'b1, 1'b0});
    add_item(8'hA5, 1, 1, '{8'hA5, 1'b1, 1'b1, 1'b1});
    // two-byte pattern, three-byte replacement, with partial and overlap
    add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h6261);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
    add_item(8'h78, 0); add_item(8'h61, 0); add_item(8'h62, 0);
    add_item(8'h61, 0); add_item(8'h61, 0); add_item(8'h62, 0);
    add_item(8'h61, 1);
    // empty end marker: match with empty replacement on the final byte
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    add_item(8'h61, 0);
    add_item(8'h62, 1, 1, '{8'h00, 1'b0, 1'b1, 1'b1});
    // replace-first mode
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
    add_cfg(sfr_pkg::REG_REPLACE_ALL, 64'd0);
    add_item(8'h61, 0); add_item(8'h62, 0); add_item(8'h61, 0);
    add_item(8'h62, 1);
    // mode changed mid-text after a replacement
    add_cfg(sfr_pkg::REG_REPLACE_ALL, 64'd1);
    add_item(8'h61, 0); add_item(8'h62, 0); add_item(8'h61, 0);
    add_cfg(sfr_pkg::REG_REPLACE_ALL, 64'd0);
    add_item(8'h62, 1);
    // pattern shortened while bytes are held
    add_cfg(sfr_pkg::REG_REPLACE_ALL, 64'd1);
    add_item(8'h61, 0);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
    add_item(8'h62, 1);
    // full-width pattern and replacement, lengths above the limit saturate
    add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
    add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd12);
    for (int i = 0; i < 8; i++) add_item(8'hFF, 0);
    add_item(8'hFF, 0); add_item(8'h00, 1);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].b, plan[i].fin, plan[i].has_exp, plan[i].exp_r);
      end
    end

    // random phases: fresh settings, texts built mostly from pattern bytes
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      calm = (ph % 4 == 3);
      write_reg(sfr_pkg::REG_PATTERN_BYTES, (ph == 1) ? {$urandom, $urandom} :
                {8{8'h61}} + ({$urandom, $urandom} & {8{8'h03}}));
      write_reg(sfr_pkg::REG_PATTERN_LENGTH,
                64'((ph == 0) ? 0 : (ph == 2) ? 8 : $urandom_range(1, 8)));
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH,
                64'((ph == 2) ? 8 : $urandom_range(0, 8)));
      write_reg(sfr_pkg::REG_REPLACE_ALL, 64'(ph % 3 != 1));
      plen = (pat_len > 8) ? 8 : pat_len;
      left = 36;
      while (left > 0) begin
        chunk = $urandom_range(1, 12);
        if (chunk > left) chunk = left;
        for (int j = 0; j < chunk; j++) begin
          // now and then drop in the whole pattern
          if (plen > 0 && j + plen < chunk && $urandom_range(0, 3) == 0) begin
            for (int q = 0; q < plen; q++) send_item(pat_word[8*q +: 8], 0, 0, '0);
            j += plen - 1;
          end else begin
            send_item(text_byte(plen), j == chunk - 1, 0, '0);
          end
        end
        left -= chunk;
      end
    end

    drain();
    $display("Sent %0d items in %0d texts phases, %0d register writes, %0d results checked.",
             items_sent, 9, cfg_writes, results_seen);
    $display("Covered pass-through, replace-all, replace-first, saturation and end markers.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
